// File: hdl/faas_pkg.sv
// ----------------------------------------------------------------------------
// faas_pkg
// Shared types, constants and helpers for the local alignment scorer.
// ----------------------------------------------------------------------------
package faas_pkg;

    localparam int CELL_W = 16;
    localparam int GAP_W  = 17;

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_RSVD   = 2'd3;

    localparam logic [2:0] REG_EXACT    = 3'd0;
    localparam logic [2:0] REG_CASE     = 3'd1;
    localparam logic [2:0] REG_MISMATCH = 3'd2;
    localparam logic [2:0] REG_BOUNDARY = 3'd3;
    localparam logic [2:0] REG_GAP_OPEN = 3'd4;
    localparam logic [2:0] REG_GAP_EXT  = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;

    localparam logic signed [GAP_W-1:0] GAP_MIN = {1'b1, {(GAP_W-1){1'b0}}};

    typedef struct packed {
        logic [6:0]        exact_bonus;
        logic [6:0]        case_bonus;
        logic signed [7:0] mismatch_score;
        logic [6:0]        boundary_bonus;
        logic signed [7:0] gap_open_score;
        logic signed [7:0] gap_extend_score;
        logic              boundary_mode;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic col_start;
        logic row_step;
        logic col_end;
    } dp_cmd_t;

    typedef struct packed {
        logic last_row;
        logic empty;
    } dp_status_t;

    function automatic logic sep_char(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h3A) ||
               (c == 8'h2D) || (c == 8'h3D) || (c == 8'h2C);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic signed [GAP_W-1:0] clamp_gap(input logic signed [19:0] v);
        if (v < 20'sh_F0000)
            return GAP_MIN;
        else if (v > 20'sh0FFFF)
            return 17'sh0FFFF;
        else
            return v[GAP_W-1:0];
    endfunction

endpackage

// File: hdl/faas_stream_if.sv
// ----------------------------------------------------------------------------
// faas_stream_if
// Valid/ready channel carrying a payload of configurable type.
// ----------------------------------------------------------------------------
interface faas_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/fuzzy_affine_local_align_score.sv
// ----------------------------------------------------------------------------
// fuzzy_affine_local_align_score
// Affine-gap local alignment scorer, query stored, target streamed.
//
//   channel  dir  payload
//   in       in   kind[1:0], char_code[7:0]
//   out      out  best_score[15:0], query_overflow
//   cfg      in   cfg_we, cfg_index[2:0], cfg_data[7:0]
//
// A target item is scored by one shared cell unit walking the query rows;
// no new item is taken until the walk ends. Reset clears the control and
// alignment state and loads default settings; finish clears the query and
// alignment state. The result sits in an output register, so query and
// target items are taken while it waits; a further finish stalls until the pending result is accepted.
// ----------------------------------------------------------------------------
module fuzzy_affine_local_align_score
    import faas_pkg::*;
#(
    parameter int QUERY_MAX = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    faas_stream_if.sink               in,
    faas_stream_if.source             out,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [7:0]                cfg_data
);

    localparam int IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int LEN_W = $clog2(QUERY_MAX + 1);

    cfg_t              cfg_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              query_we;
    logic              capture;
    logic [CELL_W-1:0] best;
    logic              overflow;
    logic [CELL_W-1:0] score_reg;
    logic              ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exact_bonus      <= 7'd3;
            cfg_reg.case_bonus       <= 7'd2;
            cfg_reg.mismatch_score   <= -8'sd1;
            cfg_reg.boundary_bonus   <= 7'd2;
            cfg_reg.gap_open_score   <= -8'sd3;
            cfg_reg.gap_extend_score <= -8'sd1;
            cfg_reg.boundary_mode    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EXACT:    cfg_reg.exact_bonus      <= cfg_data[6:0];
                REG_CASE:     cfg_reg.case_bonus       <= cfg_data[6:0];
                REG_MISMATCH: cfg_reg.mismatch_score   <= cfg_data;
                REG_BOUNDARY: cfg_reg.boundary_bonus   <= cfg_data[6:0];
                REG_GAP_OPEN: cfg_reg.gap_open_score   <= cfg_data;
                REG_GAP_EXT:  cfg_reg.gap_extend_score <= cfg_data;
                REG_MODE:     cfg_reg.boundary_mode    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    faas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_kind   (in.payload.kind),
        .in_ready  (in.ready),
        .out_ready (out.ready),
        .out_valid (out.valid),
        .status    (status),
        .cmd       (cmd),
        .query_we  (query_we),
        .capture   (capture)
    );

    faas_datapath #(
        .QUERY_MAX (QUERY_MAX),
        .IDX_W     (IDX_W),
        .LEN_W     (LEN_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .query_we (query_we),
        .char_in  (in.payload.char_code),
        .status   (status),
        .best     (best),
        .overflow (overflow)
    );

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            score_reg   <= best;
            ovf_out_reg <= overflow;
        end
    end

    assign out.payload.best_score     = score_reg;
    assign out.payload.query_overflow = ovf_out_reg;

endmodule

// File: hdl/faas_datapath.sv
// ----------------------------------------------------------------------------
// faas_datapath
// Query store, score and gap columns, and one shared cell unit that walks
// the query rows one per cycle.
// ----------------------------------------------------------------------------
module faas_datapath
    import faas_pkg::*;
#(
    parameter int QUERY_MAX = 32,
    parameter int IDX_W     = 5,
    parameter int LEN_W     = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  dp_cmd_t          cmd,
    input  logic             query_we,
    input  logic [7:0]       char_in,
    output dp_status_t       status,
    output logic [CELL_W-1:0] best,
    output logic             overflow
);

    logic [7:0]              query_mem [QUERY_MAX];
    logic [CELL_W-1:0]       score_mem [QUERY_MAX];
    logic signed [GAP_W-1:0] gap_mem   [QUERY_MAX];
    logic [QUERY_MAX-1:0]    valid_reg;

    logic [LEN_W-1:0]        len_reg;
    logic                    ovf_reg;
    logic                    pdelim_reg;
    logic                    started_reg;
    logic [CELL_W-1:0]       best_reg;
    logic [IDX_W-1:0]        row_reg;
    logic [7:0]              c_reg;
    logic                    d_reg;
    logic [CELL_W-1:0]       diag_reg;
    logic [CELL_W-1:0]       hup_reg;
    logic signed [GAP_W-1:0] f_reg;

    logic [7:0]              q_rd_reg;
    logic [CELL_W-1:0]       h_rd_reg;
    logic signed [GAP_W-1:0] e_rd_reg;
    logic                    v_rd_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    q_wr;

    logic [7:0]              q;
    logic [CELL_W-1:0]       hleft;
    logic signed [GAP_W-1:0] eprev;
    logic signed [19:0]      t_e;
    logic signed [19:0]      t_f;
    logic signed [GAP_W-1:0] e_ext;
    logic signed [GAP_W-1:0] e_val;
    logic signed [GAP_W-1:0] f_ext;
    logic signed [GAP_W-1:0] f_val;
    logic                    bonus;
    logic signed [19:0]      s;
    logic signed [19:0]      diag;
    logic signed [19:0]      h;
    logic [CELL_W-1:0]       h_sat;
    logic [LEN_W-1:0]        row_ext;

    // row data is registered in the cycle before the cell unit uses it
    assign rd_addr = cmd.col_start ? '0 : row_reg + 1'b1;
    assign q_wr    = query_we && !started_reg && (len_reg < LEN_W'(QUERY_MAX));

    assign row_ext = LEN_W'(row_reg);
    assign q       = q_rd_reg;
    assign hleft   = v_rd_reg ? h_rd_reg : '0;
    assign eprev   = v_rd_reg ? e_rd_reg : GAP_MIN;

    always_comb
    begin
        e_ext = clamp_gap(20'(eprev) + 20'(cfg.gap_extend_score));
        t_e   = $signed({4'b0, hleft}) + 20'(cfg.gap_open_score)
                + 20'(cfg.gap_extend_score);
        e_val = clamp_gap((t_e > 20'(e_ext)) ? t_e : 20'(e_ext));
        f_ext = clamp_gap(20'(f_reg) + 20'(cfg.gap_extend_score));
        t_f   = $signed({4'b0, hup_reg}) + 20'(cfg.gap_open_score)
                + 20'(cfg.gap_extend_score);
        f_val = clamp_gap((t_f > 20'(f_ext)) ? t_f : 20'(f_ext));
        if (!cfg.boundary_mode)
            bonus = ((row_reg == '0) || (row_ext + 1'b1 == len_reg)) && (pdelim_reg != d_reg);
        else
            bonus = (row_reg == '0) && pdelim_reg && !d_reg;
        if (q == c_reg)
            s = 20'(cfg.exact_bonus) + (bonus ? 20'(cfg.boundary_bonus) : 20'sd0);
        else if (fold_case(q) == fold_case(c_reg))
            s = 20'(cfg.case_bonus) + (bonus ? 20'(cfg.boundary_bonus) : 20'sd0);
        else
            s = 20'(cfg.mismatch_score);
        diag = $signed({4'b0, diag_reg}) + s;
        h = '0;
        if (diag > h)
            h = diag;
        if (20'(e_val) > h)
            h = 20'(e_val);
        if (20'(f_val) > h)
            h = 20'(f_val);
        h_sat = (h > 20'sh0FFFF) ? {CELL_W{1'b1}} : h[CELL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
            query_mem[len_reg[IDX_W-1:0]] <= char_in;
        if (cmd.row_step)
        begin
            score_mem[row_reg] <= h_sat;
            gap_mem[row_reg]   <= e_val;
        end
        if (cmd.col_start || cmd.row_step)
        begin
            q_rd_reg <= query_mem[rd_addr];
            h_rd_reg <= score_mem[rd_addr];
            e_rd_reg <= gap_mem[rd_addr];
            v_rd_reg <= valid_reg[rd_addr];
        end
        if (cmd.col_start)
        begin
            c_reg <= char_in;
            d_reg <= sep_char(char_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            pdelim_reg  <= 1'b0;
            started_reg <= 1'b0;
            best_reg    <= '0;
            row_reg     <= '0;
            diag_reg    <= '0;
            hup_reg     <= '0;
            f_reg       <= GAP_MIN;
        end
        else if (cmd.clear)
        begin
            valid_reg   <= '0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            pdelim_reg  <= 1'b0;
            started_reg <= 1'b0;
            best_reg    <= '0;
        end
        else
        begin
            if (query_we && !started_reg)
            begin
                if (len_reg < LEN_W'(QUERY_MAX))
                    len_reg <= len_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.col_start)
            begin
                row_reg  <= '0;
                diag_reg <= '0;
                hup_reg  <= '0;
                f_reg    <= GAP_MIN;
            end
            if (cmd.row_step)
            begin
                valid_reg[row_reg] <= 1'b1;
                diag_reg <= hleft;
                hup_reg  <= h_sat;
                f_reg    <= f_val;
                row_reg  <= row_reg + 1'b1;
                if (h_sat > best_reg)
                    best_reg <= h_sat;
            end
            if (cmd.col_end)
            begin
                pdelim_reg  <= d_reg;
                started_reg <= 1'b1;
            end
        end
    end

    assign status.last_row = (row_ext + 1'b1 == len_reg);
    assign status.empty    = (len_reg == '0);
    assign best            = best_reg;
    assign overflow        = ovf_reg;

endmodule

// File: hdl/faas_ctrl.sv
// ----------------------------------------------------------------------------
// faas_ctrl
// Sequencer: accepts items, walks query rows per target char, emits result.
// ----------------------------------------------------------------------------
module faas_ctrl
    import faas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       query_we,
    output logic       capture
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROWS = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       acc;

    // only a finish has to wait for the output register to free up
    assign in_ready = (state_reg == ST_IDLE) &&
                      ((in_kind != KIND_FINISH) || !ov_reg || out_ready);
    assign acc      = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next    = state_reg;
        ov_next       = ov_reg && !out_ready;
        cmd           = '0;
        query_we      = 1'b0;
        capture       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (in_kind)
                        KIND_QUERY:  query_we = 1'b1;
                        KIND_TARGET:
                        begin
                            cmd.col_start = 1'b1;
                            state_next = status.empty ? ST_END : ST_ROWS;
                        end
                        KIND_FINISH:
                        begin
                            capture   = 1'b1;
                            cmd.clear = 1'b1;
                            ov_next   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROWS:
            begin
                cmd.row_step = 1'b1;
                if (status.last_row)
                    state_next = ST_END;
            end
            ST_END:
            begin
                cmd.col_end = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// File: verif/fuzzy_affine_local_align_score_tb.sv
// ----------------------------------------------------------------------------
// fuzzy_affine_local_align_score_tb
// Streams query, target and finish transactions into the alignment scorer,
// predicts every best score with an affine-gap local alignment model kept
// in the bench, and checks each result against it. Covers several scoring
// settings, both boundary modes, overflow, noise and long output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fuzzy_affine_local_align_score_tb;
    import faas_pkg::*;

    localparam int QMAX     = 32;
    localparam int WD_LIMIT = 20000;
    localparam int SETTLE   = 60;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
    } sym_t;

    typedef struct packed {
        logic [15:0] best_score;
        logic        query_overflow;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_EXACT;
    logic [7:0] cfg_data = '0;

    faas_stream_if #(.payload_t(sym_t))   in_ch ();
    faas_stream_if #(.payload_t(score_t)) out_ch ();

    fuzzy_affine_local_align_score #(.QUERY_MAX(QMAX)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch.sink),
        .out       (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // scoring settings and alignment state mirrored in the bench
    int  exact_b, case_b, mism_s, bound_b, gopen_s, gext_s, bmode;
    logic [7:0] qchars [QMAX];
    int  qlen, hcol [QMAX], ecol [QMAX], best;
    bit  pdelim, started, ovf;

    sym_t   pending_syms [$];
    score_t expected_scores [$];

    int  send_idle = 0, recv_idle = 0, hold_cycles = 0;
    int  errors = 0, scores_seen = 0, syms_sent = 0, wd_count = 0;

    function automatic bit delim(input logic [7:0] c);
        return c == " " || c == "_" || c == "." || c == ":" || c == "-" ||
               c == "=" || c == ",";
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic int sat_gap(input int v);
        return v < -65536 ? -65536 : (v > 65535 ? 65535 : v);
    endfunction

    function automatic void clear_align();
        qlen = 0; pdelim = 0; best = 0; started = 0; ovf = 0;
        for (int i = 0; i < QMAX; i++)
        begin
            hcol[i] = 0;
            ecol[i] = -65536;
        end
    endfunction

    function automatic void score_column(input logic [7:0] c);
        bit d, bon;
        int oe, diag_prev, hup, f, hleft, e, h, s, t;
        d = delim(c);
        oe = gopen_s + gext_s;
        diag_prev = 0; hup = 0; f = -65536;
        for (int i = 0; i < qlen; i++)
        begin
            hleft = hcol[i];
            e = sat_gap(ecol[i] + gext_s);
            t = hleft + oe;
            if (t > e) e = t;
            e = sat_gap(e);
            f = sat_gap(f + gext_s);
            t = hup + oe;
            if (t > f) f = t;
            f = sat_gap(f);
            if (bmode == 0)
                bon = (i == 0 || i + 1 == qlen) && (pdelim != d);
            else
                bon = (i == 0) && pdelim && !d;
            if (qchars[i] == c)
                s = exact_b + (bon ? bound_b : 0);
            else if (lower(qchars[i]) == lower(c))
                s = case_b + (bon ? bound_b : 0);
            else
                s = mism_s;
            h = diag_prev + s;
            if (h < 0) h = 0;
            if (e > h) h = e;
            if (f > h) h = f;
            if (h > 65535) h = 65535;
            diag_prev = hleft;
            hcol[i] = h;
            ecol[i] = e;
            hup = h;
            if (h > best) best = h;
        end
        pdelim = d;
        started = 1;
    endfunction

    function automatic void predict(input sym_t x);
        score_t r;
        case (x.kind)
            KIND_QUERY:
                if (!started)
                begin
                    if (qlen < QMAX)
                    begin
                        qchars[qlen] = x.char_code;
                        qlen++;
                    end
                    else
                        ovf = 1;
                end
            KIND_TARGET:
                score_column(x.char_code);
            KIND_FINISH:
            begin
                r.best_score = best[15:0];
                r.query_overflow = ovf;
                expected_scores.push_back(r);
                clear_align();
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_syms.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                in_ch.payload <= pending_syms.pop_front();
                in_ch.valid <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= $urandom_range(99) >= recv_idle;
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            wd_count = wd_count + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                predict(in_ch.payload);
                syms_sent = syms_sent + 1;
                wd_count = 0;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                wd_count = 0;
                scores_seen = scores_seen + 1;
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected result best_score=%0d query_overflow=%0b",
                             $time, out_ch.payload.best_score,
                             out_ch.payload.query_overflow);
                    errors = errors + 1;
                end
                else
                begin
                    score_t want;
                    want = expected_scores.pop_front();
                    if (out_ch.payload.best_score !== want.best_score)
                    begin
                        $display("%0t: best_score expected %0d actual %0d", $time,
                                 want.best_score, out_ch.payload.best_score);
                        errors = errors + 1;
                    end
                    if (out_ch.payload.query_overflow !== want.query_overflow)
                    begin
                        $display("%0t: query_overflow expected %0b actual %0b", $time,
                                 want.query_overflow, out_ch.payload.query_overflow);
                        errors = errors + 1;
                    end
                end
            end
            if (wd_count >= WD_LIMIT)
            begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, WD_LIMIT);
                $display("fuzzy_affine_local_align_score_tb failed");
                $finish;
            end
        end
    end

    task automatic push(input logic [1:0] k, input logic [7:0] c);
        sym_t x;
        x.kind = k;
        x.char_code = c;
        pending_syms.push_back(x);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[7:0];
        case (idx)
            REG_EXACT:    exact_b = v & 8'h7F;
            REG_CASE:     case_b  = v & 8'h7F;
            REG_MISMATCH: mism_s  = $signed(v[7:0]);
            REG_BOUNDARY: bound_b = v & 8'h7F;
            REG_GAP_OPEN: gopen_s = $signed(v[7:0]);
            REG_GAP_EXT:  gext_s  = $signed(v[7:0]);
            default:      bmode   = v & 1;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input int ex, cs, mm, bb, go, ge, md);
        write_reg(REG_EXACT, ex);
        write_reg(REG_CASE, cs);
        write_reg(REG_MISMATCH, mm);
        write_reg(REG_BOUNDARY, bb);
        write_reg(REG_GAP_OPEN, go);
        write_reg(REG_GAP_EXT, ge);
        write_reg(REG_MODE, md);
    endtask

    task automatic drain();
        wait (pending_syms.size() == 0 && expected_scores.size() == 0);
        repeat (SETTLE) @(posedge clk);
        wait (!in_ch.valid && expected_scores.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random alignment jobs: mostly well formed with some noise
    task automatic random_jobs(input int n_syms);
        logic [7:0] q [$];
        logic [7:0] c;
        int n, nt, added;
        added = 0;
        while (added < n_syms)
        begin
            q.delete();
            case ($urandom_range(19))
                0:       n = 0;
                1:       n = $urandom_range(32, 36);
                default: n = $urandom_range(1, 10);
            endcase
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(9))
                    0, 1:    c = "_";
                    2:       c = 8'($urandom_range(255));
                    default: c = 8'($urandom_range("a", "f") ^ ($urandom_range(1) << 5));
                endcase
                if (c == "_" && $urandom_range(1)) c = "-";
                q.push_back(c);
                push(KIND_QUERY, c);
            end
            nt = $urandom_range(0, 16);
            for (int j = 0; j < nt; j++)
            begin
                case ($urandom_range(9))
                    0, 1: c = ($urandom_range(1) ? " " : ".");
                    2:    c = 8'($urandom_range(255));
                    3:    c = ($urandom_range(1) ? ":" : ($urandom_range(1) ? "=" : ","));
                    default:
                    begin
                        c = (q.size() > 0) ? q[$urandom_range(q.size() - 1)]
                                           : 8'($urandom_range(255));
                        if ($urandom_range(3) == 0 && lower(c) != c) c = lower(c);
                        else if ($urandom_range(3) == 0 && c >= "a" && c <= "z")
                            c = c - 8'd32;
                    end
                endcase
                push(KIND_TARGET, c);
                if ($urandom_range(29) == 0) push(KIND_QUERY, 8'($urandom_range(255)));
                if ($urandom_range(39) == 0) push(KIND_RSVD, 8'($urandom_range(255)));
            end
            push(KIND_FINISH, 8'($urandom_range(255)));
            added += n + nt + 1;
        end
    endtask

    initial
    begin
        exact_b = 3; case_b = 2; mism_s = -1; bound_b = 2;
        gopen_s = -3; gext_s = -1; bmode = 0;
        clear_align();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: case folding, boundaries, empty query, overflow, noise
        send_idle = 13; recv_idle = 81;
        push(KIND_QUERY, "A"); push(KIND_QUERY, "b"); push(KIND_QUERY, 8'hFF);
        push(KIND_TARGET, " "); push(KIND_TARGET, "a"); push(KIND_TARGET, "B");
        push(KIND_TARGET, 8'hFF); push(KIND_TARGET, 8'h00);
        push(KIND_QUERY, "x");
        push(KIND_RSVD, 8'hAA);
        push(KIND_FINISH, 8'h55);
        push(KIND_TARGET, "z"); push(KIND_FINISH, 8'h00);
        for (int i = 0; i < 33; i++) push(KIND_QUERY, (i % 2) ? 8'h00 : "Z");
        push(KIND_TARGET, "z"); push(KIND_TARGET, "Z");
        push(KIND_FINISH, 8'hFF);
        push(KIND_FINISH, 8'h00);
        drain();

        set_all(127, 127, -128, 127, -128, -128, 1);
        push(KIND_QUERY, "a"); push(KIND_QUERY, "q");
        push(KIND_TARGET, "_"); push(KIND_TARGET, "A"); push(KIND_TARGET, "q");
        push(KIND_TARGET, "_"); push(KIND_TARGET, "a");
        push(KIND_FINISH, 8'h00);
        random_jobs(300);
        drain();

        set_all(0, 0, 0, 0, 0, 0, 0);
        random_jobs(150);
        drain();

        send_idle = 81; recv_idle = 13;
        set_all(5, 1, -2, 7, -5, -1, 1);
        random_jobs(400);
        drain();

        // receiver holds off while finishes keep arriving
        send_idle = 0; recv_idle = 0;
        set_all(20, 9, -7, 3, -2, 0, 0);
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
        begin
            push(KIND_QUERY, "k"); push(KIND_TARGET, "k"); push(KIND_FINISH, 8'h00);
        end
        random_jobs(500);
        drain();

        $display("%0d transactions sent, %0d scores checked, %0d mismatches",
                 syms_sent, scores_seen, errors);
        $display("settings covered: extremes, both boundary modes, overflow, long stall");
        if (errors == 0)
            $display("fuzzy_affine_local_align_score_tb passed");
        else
            $display("fuzzy_affine_local_align_score_tb failed");
        $finish;
    end

endmodule
